@@ src/uranger_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package uranger_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CNT_W      = 20;
    localparam int ECHO_W     = 16;
    localparam int DIST_W     = 11;
    localparam int ALERT_W    = 9;
    localparam int DIV_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ALERT_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_HOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN    = 3'd4;

    localparam logic [ECHO_W-1:0] ECHO_MAX = 16'hFFFF;
    localparam logic [DIST_W-1:0] DIST_MAX = 11'h7FF;

    typedef enum logic [4:0] {
        PH_TRIGGER = 5'b00001,
        PH_WAIT    = 5'b00010,
        PH_MEASURE = 5'b00100,
        PH_ALERT   = 5'b01000,
        PH_GAP     = 5'b10000
    } t_phase;

endpackage

`default_nettype wire

@@ src/ultrasonic_ranger_with_alert.sv @@
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat's result is registered in the output register. One beat per cycle is
// taken unless the full output register is stalled; a new beat enters while the last drains.
// Reset (synchronous, active low): trigger phase, counters zero, registers at defaults,
// output register empty.
module ultrasonic_ranger_with_alert
    import uranger_pkg::*;
#(
    parameter int DIST_DIVISOR = 58
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_echo_level,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_trigger_level,
    output logic                       o_alert_level,
    output logic                       o_distance_valid,
    output logic [DIST_W-1:0]          o_distance_cm
);

    localparam int RECIP_SHIFT = ECHO_W + DIV_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = ECHO_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int THR_W       = ALERT_W + DIV_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIST_DIVISOR) - 64'd1) / 64'(DIST_DIVISOR));
    localparam logic [DIV_W-1:0] DIV_K = DIV_W'(DIST_DIVISOR);

    logic [ALERT_W-1:0] r_alert_dist;
    logic [ECHO_W-1:0]  r_max_echo;
    logic [DIV_W-1:0]   r_trig_len;
    logic [CNT_W-1:0]   r_alert_hold;
    logic [CNT_W-1:0]   r_gap_len;

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ECHO_W-1:0]  r_echo_cnt, n_echo_cnt;

    logic               r_out_valid;
    logic               r_trig, n_trig;
    logic               r_alert, n_alert;
    logic               r_dv, n_dv;
    logic [DIST_W-1:0]  r_dist, n_dist;

    logic               w_accept;
    logic [CNT_W-1:0]   w_cnt_inc;
    logic [CNT_W-1:0]   w_trig_len;
    logic [PROD_W-1:0]  w_prod;
    logic [QUOT_W-1:0]  w_quot;
    logic [THR_W-1:0]   w_thr;
    logic               w_in_range;
    logic               w_fire;
    t_phase             w_after;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alert_dist <= ALERT_W'(15);
            r_max_echo   <= ECHO_W'(23200);
            r_trig_len   <= DIV_W'(10);
            r_alert_hold <= CNT_W'(500000);
            r_gap_len    <= CNT_W'(100000);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ALERT_DIST: r_alert_dist <= i_cfg_data[ALERT_W-1:0];
                REG_MAX_ECHO:   r_max_echo   <= i_cfg_data[ECHO_W-1:0];
                REG_TRIG_LEN:   r_trig_len   <= i_cfg_data[DIV_W-1:0];
                REG_ALERT_HOLD: r_alert_hold <= i_cfg_data;
                REG_GAP_LEN:    r_gap_len    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cnt_inc  = r_cnt + CNT_W'(1);
    assign w_trig_len = (r_trig_len == '0) ? CNT_W'(1) : CNT_W'(r_trig_len);
    assign w_after    = (r_gap_len != '0) ? PH_GAP : PH_TRIGGER;

    // count / divisor by reciprocal multiply, exact over the 16-bit count range
    assign w_prod     = PROD_W'(r_echo_cnt) * PROD_W'(RECIP);
    assign w_quot     = w_prod[PROD_W-1:RECIP_SHIFT];
    assign w_in_range = r_echo_cnt <= r_max_echo;
    // dist < threshold, checked on the raw count
    assign w_thr      = THR_W'(r_alert_dist) * THR_W'(DIV_K);
    assign w_fire     = w_in_range ? (THR_W'(r_echo_cnt) < w_thr) : (r_alert_dist != '0);

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_echo_cnt = r_echo_cnt;
        n_trig     = 1'b0;
        n_alert    = 1'b1;
        n_dv       = 1'b0;
        n_dist     = '0;
        unique case (r_phase)
            PH_WAIT: begin
                if (i_echo_level) begin
                    n_echo_cnt = ECHO_W'(1);
                    n_phase    = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (i_echo_level) begin
                    if (r_echo_cnt != ECHO_MAX) begin
                        n_echo_cnt = r_echo_cnt + ECHO_W'(1);
                    end
                end else begin
                    n_dv = 1'b1;
                    if (w_in_range) begin
                        n_dist = (w_quot > QUOT_W'(DIST_MAX)) ? DIST_MAX : w_quot[DIST_W-1:0];
                    end
                    n_cnt   = '0;
                    n_phase = w_after;
                    if (w_fire) begin
                        n_alert = 1'b0;
                        if (r_alert_hold > CNT_W'(1)) begin
                            n_phase = PH_ALERT;
                            n_cnt   = CNT_W'(1);
                        end
                    end
                end
            end
            PH_ALERT: begin
                n_alert = 1'b0;
                n_cnt   = w_cnt_inc;
                if (w_cnt_inc >= r_alert_hold) begin
                    n_cnt   = '0;
                    n_phase = w_after;
                end
            end
            PH_GAP: begin
                n_cnt = w_cnt_inc;
                if (w_cnt_inc >= r_gap_len) begin
                    n_cnt   = '0;
                    n_phase = PH_TRIGGER;
                end
            end
            PH_TRIGGER: begin
                n_trig = 1'b1;
                n_cnt  = w_cnt_inc;
                if (w_cnt_inc >= w_trig_len) begin
                    n_cnt   = '0;
                    n_phase = PH_WAIT;
                end
            end
            default: begin
                // stray code: first trigger tick
                n_trig  = 1'b1;
                n_cnt   = CNT_W'(1);
                n_phase = (w_trig_len <= CNT_W'(1)) ? PH_WAIT : PH_TRIGGER;
                if (w_trig_len <= CNT_W'(1)) begin
                    n_cnt = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TRIGGER;
            r_cnt       <= '0;
            r_echo_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_cnt       <= n_cnt;
                r_echo_cnt  <= n_echo_cnt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_trig  <= n_trig;
            r_alert <= n_alert;
            r_dv    <= n_dv;
            r_dist  <= n_dist;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_trigger_level  = r_trig;
    assign o_alert_level    = r_alert;
    assign o_distance_valid = r_dv;
    assign o_distance_cm    = r_dist;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import uranger_pkg::*;

    localparam int DIV        = 58;
    localparam int TIMEOUT_NS = 5_000_000;

    typedef struct packed {
        logic              trigger;
        logic              alert;
        logic              dvalid;
        logic [DIST_W-1:0] dist_cm;
    } t_reading;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} t_stall_mode;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  echo_level;
    logic                  out_valid;
    logic                  out_stall;
    logic                  trigger_level;
    logic                  alert_level;
    logic                  distance_valid;
    logic [DIST_W-1:0]     distance_cm;

    // ranger state as predicted
    t_phase             ph;
    logic [CNT_W-1:0]   ph_cnt;
    logic [ECHO_W-1:0]  echo_cnt;
    logic [ALERT_W-1:0] alert_dist;
    logic [ECHO_W-1:0]  max_echo;
    logic [7:0]         trig_len;
    logic [CNT_W-1:0]   hold_len;
    logic [CNT_W-1:0]   gap_len;

    t_reading    pending_readings[$];
    int unsigned readings_seen = 0;
    int unsigned mismatches = 0;

    int unsigned burst_left = 0;
    int unsigned max_gap = 0;
    int unsigned hold_left = 0;
    t_stall_mode stall_mode = STALL_NONE;

    int unsigned pulse_left = 0;
    int unsigned quiet_left = 0;
    bit          armed = 1'b0;

    ultrasonic_ranger_with_alert #(.DIST_DIVISOR(DIV)) DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_echo_level     (echo_level),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_trigger_level  (trigger_level),
        .o_alert_level    (alert_level),
        .o_distance_valid (distance_valid),
        .o_distance_cm    (distance_cm)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    function automatic void leave_reading();
        ph_cnt = '0;
        ph = (gap_len != 0) ? PH_GAP : PH_TRIGGER;
    endfunction

    function automatic t_reading ranger_tick(input logic echo);
        t_reading          r;
        logic [ECHO_W-1:0] q;
        r = '0;
        r.alert = 1'b1;
        case (ph)
            PH_TRIGGER: begin
                r.trigger = 1'b1;
                ph_cnt = ph_cnt + 1'b1;
                // count is at least 1 here, so a length of 0 acts as 1
                if (ph_cnt >= CNT_W'(trig_len)) begin
                    ph = PH_WAIT;
                    ph_cnt = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    echo_cnt = 1;
                    ph = PH_MEASURE;
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (echo_cnt != ECHO_MAX) echo_cnt = echo_cnt + 1'b1;
                end else begin
                    q = (echo_cnt <= max_echo) ? echo_cnt / ECHO_W'(DIV) : '0;
                    r.dist_cm = (q > DIST_MAX) ? DIST_MAX : q[DIST_W-1:0];
                    r.dvalid = 1'b1;
                    if (r.dist_cm < alert_dist) begin
                        r.alert = 1'b0;
                        if (hold_len > 1) begin
                            ph = PH_ALERT;
                            ph_cnt = 1;
                        end else begin
                            leave_reading();
                        end
                    end else begin
                        leave_reading();
                    end
                end
            end
            PH_ALERT: begin
                r.alert = 1'b0;
                ph_cnt = ph_cnt + 1'b1;
                if (ph_cnt >= hold_len) leave_reading();
            end
            default: begin
                ph_cnt = ph_cnt + 1'b1;
                if (ph_cnt >= gap_len) begin
                    ph = PH_TRIGGER;
                    ph_cnt = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        t_reading got;
        t_reading want;
        if (rst_n && out_valid && !out_stall) begin
            got = {trigger_level, alert_level, distance_valid, distance_cm};
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("%0t unexpected beat %p", $time, got);
            end else begin
                want = pending_readings.pop_front();
                check_field("trigger_level", want.trigger, got.trigger);
                check_field("alert_level", want.alert, got.alert);
                check_field("distance_valid", want.dvalid, got.dvalid);
                check_field("distance_cm", want.dist_cm, got.dist_cm);
            end
        end
    end

    initial begin
        int unsigned tick;
        out_stall = 1'b0;
        tick = 0;
        forever begin
            @(negedge clk);
            tick++;
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                case (stall_mode)
                    STALL_RANDOM:   out_stall = ($urandom_range(0, 2) == 0);
                    STALL_PERIODIC: out_stall = ((tick % 5) < 2);
                    default:        out_stall = 1'b0;
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_DATA_W-1:0];
        case (idx)
            REG_ALERT_DIST: alert_dist = value[ALERT_W-1:0];
            REG_MAX_ECHO:   max_echo = value[ECHO_W-1:0];
            REG_TRIG_LEN:   trig_len = value[7:0];
            REG_ALERT_HOLD: hold_len = value[CNT_W-1:0];
            REG_GAP_LEN:    gap_len = value[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input int unsigned alert, input int unsigned max_ticks,
                              input int unsigned trig, input int unsigned hold,
                              input int unsigned gap);
        write_reg(REG_ALERT_DIST, alert);
        write_reg(REG_MAX_ECHO, max_ticks);
        write_reg(REG_TRIG_LEN, trig);
        write_reg(REG_ALERT_HOLD, hold);
        write_reg(REG_GAP_LEN, gap);
    endtask

    task automatic send_beat(input logic echo);
        int unsigned gap;
        t_reading    r;
        @(negedge clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid = 1'b1;
        echo_level = echo;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = ranger_tick(echo);
        if (r.dvalid) readings_seen++;
        pending_readings.push_back(r);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // echo pulses aimed at the wait phase, with stray and cut-short pulses mixed in
    function automatic logic next_echo();
        if (ph != PH_WAIT && ph != PH_MEASURE) armed = 1'b0;
        if (ph == PH_WAIT && !armed) begin
            armed = 1'b1;
            quiet_left = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0: pulse_left = $urandom_range(1, 20);
                1: pulse_left = $urandom_range(1, 30);
                2: pulse_left = (max_echo <= 300) ? max_echo + $urandom_range(0, 2)
                                                  : $urandom_range(1, 60);
                default: pulse_left = (alert_dist != 0 && alert_dist <= 5)
                        ? $urandom_range(58 * alert_dist - 1, 58 * alert_dist)
                        : $urandom_range(1, 60);
            endcase
        end
        if (armed && quiet_left > 0) begin
            quiet_left--;
            return 1'b0;
        end
        if (armed && pulse_left > 0) begin
            if ($urandom_range(0, 39) == 0) begin
                pulse_left = 0;
                return 1'b0;
            end
            pulse_left--;
            return 1'b1;
        end
        return ($urandom_range(0, 15) == 0);
    endfunction

    task automatic test_reset_values();
        max_gap = 3;
        stall_mode = STALL_RANDOM;
        // echo is ignored during the 10 trigger beats
        for (int k = 0; k < 10; k++) send_beat(k[0]);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        wait_idle();
    endtask

    task automatic test_lowered_bounds();
        write_reg(REG_ALERT_HOLD, 20'hFFFFF);
        send_beat(1'b0);
        wait_idle();
        write_reg(REG_ALERT_HOLD, 1);
        send_beat(1'b1);
        wait_idle();
        write_reg(REG_GAP_LEN, 20'hFFFFF);
        send_beat(1'b0);
        wait_idle();
        write_reg(REG_GAP_LEN, 0);
        send_beat(1'b1);
        send_beat(1'b0);
        wait_idle();
    endtask

    task automatic test_zero_trigger_no_alert();
        set_config(0, 0, 0, 1, 0);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        wait_idle();
    endtask

    task automatic test_random_ranging();
        int unsigned start;
        for (int p = 0; p < 9; p++) begin
            wait_idle();
            set_config((p == 0) ? 400 : (p == 1) ? 0 : $urandom_range(0, 1),
                       (p == 2) ? 65535 : (p == 3) ? 0 : $urandom_range(0, 60),
                       (p == 4) ? 255 : (p == 5) ? 0 : $urandom_range(1, 4),
                       (p == 6) ? 0 : (p == 7) ? 1 : $urandom_range(2, 8),
                       (p == 8) ? 0 : $urandom_range(0, 8));
            max_gap = $urandom_range(0, 6);
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            start = readings_seen;
            while (readings_seen - start < 1) send_beat(next_echo());
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(3, 200, 2, 4, 3);
        max_gap = 0;
        stall_mode = STALL_NONE;
        hold_left = 80;
        repeat (40) send_beat(next_echo());
        wait_idle();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        echo_level = 1'b0;
        ph = PH_TRIGGER;
        ph_cnt = '0;
        echo_cnt = '0;
        alert_dist = 15;
        max_echo = 23200;
        trig_len = 10;
        hold_len = 500000;
        gap_len = 100000;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_lowered_bounds();
        test_zero_trigger_no_alert();
        test_random_ranging();
        test_backpressure();

        wait_idle();
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/uranger_pkg.sv
src/ultrasonic_ranger_with_alert.sv
bench/tb.sv
